FILE: src/gas_sensor_resistance_ratio_baseline_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gas sensor resistance block
// Concurrent checks, active in simulation and empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef GAS_SENSOR_RESISTANCE_RATIO_BASELINE_DEFINES_SVH
`define GAS_SENSOR_RESISTANCE_RATIO_BASELINE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define GSRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property at every edge, reset included
`define GSRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSRB_ASSERT(label, prop, msg)
`define GSRB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/gsrb_pkg.sv
// ---------------------------------------------------------------------------
// gsrb_pkg
// Types, codes and coefficient tables of the gas sensor resistance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsrb_pkg;

  localparam int NUM_CHANNELS_DEFAULT = 3;
  localparam int SUPPORTED_CHANNELS   = 3;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // register indexes
  typedef enum logic [2:0] {
    REG_STEP_UV   = 3'd0,
    REG_LOAD_RED  = 3'd1,
    REG_LOAD_OX   = 3'd2,
    REG_LOAD_NH3  = 3'd3,
    REG_CLEAN_LOW = 3'd4,
    REG_CLEAN_HI  = 3'd5
  } cfg_reg_t;

  localparam logic       OP_SAMPLE   = 1'b0;
  localparam logic       OP_LOAD     = 1'b1;
  localparam logic [1:0] CH_REDUCING = 2'd0;
  localparam logic [1:0] CH_OXIDIZING = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCALE,
    S_PREP,
    S_RES_LOAD,
    S_DIV_RES,
    S_RES_POST,
    S_POLY,
    S_POLY_POST,
    S_MUL_E,
    S_DIV_TEMP,
    S_TEMP_POST,
    S_RATIO_LOAD,
    S_DIV_RATIO,
    S_RATIO_POST,
    S_WINDOW,
    S_DIV_ADAPT,
    S_ADAPT_POST,
    S_DONE
  } state_t;

  // Cubic coefficients a, b, c, d (k = 0..3) and reference E20 (k = 4),
  // in units of 1e-6.
  function automatic logic signed [47:0] cubic_coef(input logic [1:0] ch,
                                                    input logic [2:0] k);
    logic signed [47:0] v;
    v = 48'sd0;
    case (ch)
      2'd0: begin
        case (k)
          3'd0: v = 48'sd1737197;
          3'd1: v = -48'sd160970300;
          3'd2: v = -48'sd3503991000;
          3'd3: v = 48'sd744662800000;
          3'd4: v = 48'sd624092446000;
          default: v = 48'sd0;
        endcase
      end
      2'd1: begin
        case (k)
          3'd0: v = -48'sd2480841;
          3'd1: v = 48'sd248541700;
          3'd2: v = -48'sd8704072000;
          3'd3: v = 48'sd151446900000;
          3'd4: v = 48'sd56935396000;
          default: v = 48'sd0;
        endcase
      end
      default: begin
        case (k)
          3'd0: v = -48'sd28557770;
          3'd1: v = 48'sd3345094000;
          3'd2: v = -48'sd140317800000;
          3'd3: v = 48'sd2504895000000;
          3'd4: v = 48'sd808114225000;
          default: v = 48'sd0;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/gas_sensor_resistance_ratio_baseline.sv
// ---------------------------------------------------------------------------
// gas_sensor_resistance_ratio_baseline
// Sensor resistance from a divider, cubic temperature correction, ratio to a
// per-channel baseline and clean-air baseline averaging.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  s_       in         s_tvalid / s_tready       s_tdata 80b, s_tuser 3b
//  m_       out        m_tvalid / m_tready       m_tdata 80b, m_tuser 3b
//  cfg_     in         cfg_write (no wait)       cfg_index 3b, cfg_data 24b
//
//  A full sample runs a 72-step restoring divider (one quotient bit per
//  cycle) up to four times, plus a 32-step shift-add multiplier for the
//  temperature scaling. A load or an invalid channel goes from the idle
//  state straight to the done state. s_tready is high only in the idle
//  state; the result waits in the output register, so the next transfer
//  may enter while it stalls. Reset (rst, synchronous) clears the
//  baselines and restores register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gas_sensor_resistance_ratio_baseline_defines.svh"

module gas_sensor_resistance_ratio_baseline #(
  parameter int NUM_CHANNELS = gsrb_pkg::NUM_CHANNELS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // adc_code[15:0], supply_mv[31:16], temperature_raw[47:32],
  // baseline_value[79:48]
  input  wire logic [79:0] s_tdata,
  // operation[0], channel[2:1]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // resistance_ohms[31:0], ratio_percent[47:32], baseline_ohms[79:48]
  output logic [79:0]      m_tdata,
  // out_channel[1:0], baseline_adapted[2]
  output logic [2:0]       m_tuser,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int DEPTH = (NUM_CHANNELS < gsrb_pkg::SUPPORTED_CHANNELS) ?
                         NUM_CHANNELS : gsrb_pkg::SUPPORTED_CHANNELS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [9:0]  step_uv;
  logic [23:0] load_red, load_ox, load_nh3;
  logic [15:0] clean_low, clean_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_uv    <= 10'd125;
      load_red   <= 24'd47000;
      load_ox    <= 24'd47000;
      load_nh3   <= 24'd47000;
      clean_low  <= 16'd90;
      clean_high <= 16'd110;
    end else if (cfg_write) begin
      case (cfg_index)
        gsrb_pkg::REG_STEP_UV:   step_uv    <= cfg_data[9:0];
        gsrb_pkg::REG_LOAD_RED:  load_red   <= cfg_data;
        gsrb_pkg::REG_LOAD_OX:   load_ox    <= cfg_data;
        gsrb_pkg::REG_LOAD_NH3:  load_nh3   <= cfg_data;
        gsrb_pkg::REG_CLEAN_LOW: clean_low  <= cfg_data[15:0];
        gsrb_pkg::REG_CLEAN_HI:  clean_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic        in_op;
  logic [1:0]  in_ch;
  logic        in_valid_ch;
  assign in_op       = s_tuser[0];
  assign in_ch       = s_tuser[2:1];
  assign in_valid_ch = (in_ch < 2'd3) && (32'(in_ch) < NUM_CHANNELS);

  gsrb_pkg::state_t state, state_next;

  // latched item
  logic [1:0]         ch;
  logic signed [15:0] code;
  logic [15:0]        supply;
  logic signed [15:0] traw;

  // working registers
  logic signed [26:0] p;
  logic [25:0]        full;
  logic [49:0]        num;
  logic [26:0]        den;
  logic signed [8:0]  tval;
  logic               t_ok;
  logic signed [47:0] acc;
  logic [1:0]         pcnt;
  logic [6:0]         cnt;
  logic [71:0]        quo;
  logic [46:0]        rem;
  logic [46:0]        dvs;
  logic [31:0]        r;
  logic [15:0]        ratio;
  logic [31:0]        base;
  logic               adapted;
  logic [31:0]        store [DEPTH];

  // output register
  logic [1:0]  o_ch;
  logic [31:0] o_r;
  logic [15:0] o_ratio;
  logic [31:0] o_base;
  logic        o_adapted;

  // divider step: one quotient bit per cycle
  logic [47:0] dshift, dsub;
  logic        dge;
  assign dshift = {rem, quo[71]};
  assign dsub   = dshift - {1'b0, dvs};
  assign dge    = dshift >= {1'b0, dvs};

  logic div_last, mul_last, poly_last;
  assign div_last  = cnt == 7'd71;
  assign mul_last  = cnt == 7'd31;
  assign poly_last = pcnt == 2'd2;

  // whole degrees, truncated toward zero; x/200 as x*5243 >> 20 (exact here)
  logic [16:0] tmag;
  logic [29:0] tprod;
  logic [7:0]  tq;
  logic signed [8:0] tsig;
  assign tmag  = traw[15] ? 17'(~{traw[15], traw} + 17'd1) : {1'b0, traw};
  assign tprod = {13'd0, tmag} * 30'd5243;
  assign tq    = tprod[27:20];
  assign tsig  = traw[15] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

  logic signed [26:0] full_s;
  logic               p_sat, p_zero;
  assign full_s = $signed({1'b0, full});
  assign p_sat  = p >= full_s;
  assign p_zero = p <= 27'sd0;

  logic [23:0] load_sel;
  always_comb begin
    case (ch)
      gsrb_pkg::CH_REDUCING:  load_sel = load_red;
      gsrb_pkg::CH_OXIDIZING: load_sel = load_ox;
      default:                load_sel = load_nh3;
    endcase
  end

  logic [31:0] r_res;
  assign r_res = (quo[71:32] != 40'd0) ? gsrb_pkg::ALL_ONES : quo[31:0];

  logic signed [56:0] pprod;
  logic signed [47:0] coef_next, coef_a, e20_full;
  assign pprod     = acc * tsig_reg();
  assign coef_next = gsrb_pkg::cubic_coef(ch, 3'(pcnt) + 3'd1);
  assign coef_a    = gsrb_pkg::cubic_coef(ch, 3'd0);
  assign e20_full  = gsrb_pkg::cubic_coef(ch, 3'd4);

  function automatic logic signed [8:0] tsig_reg();
    return tval;
  endfunction

  logic        round_up;
  logic [72:0] q_round;
  logic [31:0] r_temp;
  assign round_up = {rem, 1'b0} >= {1'b0, dvs};
  assign q_round  = {1'b0, quo} + 73'(round_up);
  assign r_temp   = (q_round[72:32] != 41'd0) ? gsrb_pkg::ALL_ONES : q_round[31:0];

  logic [31:0] b_cur;
  assign b_cur = store[ch[IDX_W-1:0]];

  logic in_window;
  assign in_window = (ratio >= clean_low) && (ratio <= clean_high);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = state == gsrb_pkg::S_IDLE;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsrb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gsrb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_valid_ch && in_op == gsrb_pkg::OP_SAMPLE) ?
                       gsrb_pkg::S_SCALE : gsrb_pkg::S_DONE;
        end
      end
      gsrb_pkg::S_SCALE: state_next = gsrb_pkg::S_PREP;
      gsrb_pkg::S_PREP: begin
        state_next = (p_sat || p_zero) ? gsrb_pkg::S_RATIO_LOAD : gsrb_pkg::S_RES_LOAD;
      end
      gsrb_pkg::S_RES_LOAD: state_next = gsrb_pkg::S_DIV_RES;
      gsrb_pkg::S_DIV_RES: if (div_last) state_next = gsrb_pkg::S_RES_POST;
      gsrb_pkg::S_RES_POST: begin
        state_next = (r_res != gsrb_pkg::ALL_ONES && t_ok) ?
                     gsrb_pkg::S_POLY : gsrb_pkg::S_RATIO_LOAD;
      end
      gsrb_pkg::S_POLY: if (poly_last) state_next = gsrb_pkg::S_POLY_POST;
      gsrb_pkg::S_POLY_POST: begin
        state_next = (acc > 48'sd1000000) ? gsrb_pkg::S_MUL_E : gsrb_pkg::S_RATIO_LOAD;
      end
      gsrb_pkg::S_MUL_E: if (mul_last) state_next = gsrb_pkg::S_DIV_TEMP;
      gsrb_pkg::S_DIV_TEMP: if (div_last) state_next = gsrb_pkg::S_TEMP_POST;
      gsrb_pkg::S_TEMP_POST: state_next = gsrb_pkg::S_RATIO_LOAD;
      gsrb_pkg::S_RATIO_LOAD: begin
        state_next = (b_cur == 32'd0) ? gsrb_pkg::S_WINDOW : gsrb_pkg::S_DIV_RATIO;
      end
      gsrb_pkg::S_DIV_RATIO: if (div_last) state_next = gsrb_pkg::S_RATIO_POST;
      gsrb_pkg::S_RATIO_POST: state_next = gsrb_pkg::S_WINDOW;
      gsrb_pkg::S_WINDOW: begin
        state_next = in_window ? gsrb_pkg::S_DIV_ADAPT : gsrb_pkg::S_DONE;
      end
      gsrb_pkg::S_DIV_ADAPT: if (div_last) state_next = gsrb_pkg::S_ADAPT_POST;
      gsrb_pkg::S_ADAPT_POST: state_next = gsrb_pkg::S_DONE;
      gsrb_pkg::S_DONE: if (out_free) state_next = gsrb_pkg::S_IDLE;
      default: state_next = gsrb_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      gsrb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          ch      <= in_ch;
          code    <= $signed(s_tdata[15:0]);
          supply  <= s_tdata[31:16];
          traw    <= $signed(s_tdata[47:32]);
          r       <= 32'd0;
          ratio   <= 16'd0;
          adapted <= 1'b0;
          base    <= (in_valid_ch && in_op == gsrb_pkg::OP_LOAD) ? s_tdata[79:48] : 32'd0;
        end
      end
      gsrb_pkg::S_SCALE: begin
        p    <= code * $signed({1'b0, step_uv});
        full <= 26'(32'(supply) * 32'd1000);
        tval <= tsig;
        t_ok <= (tsig >= -9'sd20) && (tsig <= 9'sd70);
      end
      gsrb_pkg::S_PREP: begin
        if (p_sat) begin
          r <= gsrb_pkg::ALL_ONES;
        end else if (p_zero) begin
          r <= 32'd0;
        end
        num <= {26'd0, load_sel} * {24'd0, p[25:0]};
        den <= {1'b0, full} - p;
      end
      gsrb_pkg::S_RES_LOAD: begin
        // round half up: (2 num + den) / (2 den)
        quo <= 72'({num, 1'b0}) + 72'(den);
        dvs <= 47'({den, 1'b0});
        rem <= 47'd0;
        cnt <= 7'd0;
      end
      gsrb_pkg::S_DIV_RES, gsrb_pkg::S_DIV_TEMP, gsrb_pkg::S_DIV_RATIO,
      gsrb_pkg::S_DIV_ADAPT: begin
        rem <= dge ? dsub[46:0] : dshift[46:0];
        quo <= {quo[70:0], dge};
        cnt <= cnt + 7'd1;
      end
      gsrb_pkg::S_RES_POST: begin
        r    <= r_res;
        acc  <= coef_a;
        pcnt <= 2'd0;
      end
      gsrb_pkg::S_POLY: begin
        // Horner step: acc * t + next coefficient
        acc  <= $signed(pprod[47:0]) + coef_next;
        pcnt <= pcnt + 2'd1;
      end
      gsrb_pkg::S_POLY_POST: begin
        dvs <= acc[46:0];
        quo <= 72'd0;
        cnt <= 7'd0;
      end
      gsrb_pkg::S_MUL_E: begin
        // shift-add, multiplier bits taken from r, top bit first
        quo <= {quo[70:0], 1'b0} + (r[31] ? 72'(e20_full[39:0]) : 72'd0);
        r   <= {r[30:0], 1'b0};
        cnt <= mul_last ? 7'd0 : cnt + 7'd1;
        rem <= 47'd0;
      end
      gsrb_pkg::S_TEMP_POST: r <= r_temp;
      gsrb_pkg::S_RATIO_LOAD: begin
        base  <= b_cur;
        ratio <= 16'd0;
        // r * 200 + b over 2 b
        quo <= 72'({r, 7'd0}) + 72'({r, 6'd0}) + 72'({r, 3'd0}) + 72'(b_cur);
        dvs <= 47'({b_cur, 1'b0});
        rem <= 47'd0;
        cnt <= 7'd0;
      end
      gsrb_pkg::S_RATIO_POST: begin
        ratio <= (quo[71:16] != 56'd0) ? 16'hFFFF : quo[15:0];
      end
      gsrb_pkg::S_WINDOW: begin
        // r + 999 b + 500 over 1000
        quo <= 72'({base, 10'd0}) - 72'({base, 4'd0}) - 72'({base, 3'd0}) - 72'(base)
             + 72'(r) + 72'd500;
        dvs <= 47'd1000;
        rem <= 47'd0;
        cnt <= 7'd0;
      end
      gsrb_pkg::S_ADAPT_POST: begin
        base    <= quo[31:0];
        adapted <= 1'b1;
      end
      default: ;
    endcase
  end

  // baseline store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= 32'd0;
      end
    end else if (state == gsrb_pkg::S_IDLE && s_tvalid && in_valid_ch &&
                 in_op == gsrb_pkg::OP_LOAD) begin
      store[in_ch[IDX_W-1:0]] <= s_tdata[79:48];
    end else if (state == gsrb_pkg::S_ADAPT_POST) begin
      store[ch[IDX_W-1:0]] <= quo[31:0];
    end
  end

  // output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == gsrb_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gsrb_pkg::S_DONE && out_free) begin
      o_ch      <= ch;
      o_r       <= r;
      o_ratio   <= ratio;
      o_base    <= base;
      o_adapted <= adapted;
    end
  end

  assign m_tdata = {o_base, o_ratio, o_r};
  assign m_tuser = {o_adapted, o_ch};

  // checks
  `GSRB_ASSERT(a_one_item, ((s_tvalid && s_tready) |=> !s_tready), "second item taken while busy")
  `GSRB_ASSERT(a_div_nonzero, ((state == gsrb_pkg::S_DIV_RES || state == gsrb_pkg::S_DIV_TEMP || state == gsrb_pkg::S_DIV_RATIO || state == gsrb_pkg::S_DIV_ADAPT) |-> (dvs != 47'd0)), "divider runs on zero")
  `GSRB_ASSERT_ALWAYS(a_reset_out, ($past(rst) |-> !m_tvalid), "result valid after reset")

endmodule

`default_nettype wire
